@@ sv/ihex_pkg.sv @@
// Shared types and constants for the Intel HEX record loader.
`timescale 1ns / 1ps
`default_nettype none
package ihex_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NL      = 8'h0A;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] DIGIT_ALPHA  = 8'h37;
	localparam logic [7:0] DIGIT_NUM    = 8'h30;

	localparam logic [31:0] START_RESET = 32'h0001_0000;

	localparam logic [7:0] REC_DATA      = 8'h00;
	localparam logic [7:0] REC_EOF       = 8'h01;
	localparam logic [7:0] REC_EXT_LIN   = 8'h04;
	localparam logic [7:0] REC_START_LIN = 8'h05;

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_SKIP,
		PH_LENGTH,
		PH_ADDR,
		PH_TYPE,
		PH_DATA,
		PH_CHECKSUM
	} phase_t;

	typedef enum logic [2:0] {
		OP_OFFSET,
		OP_ACCESS,
		OP_BASE,
		OP_START,
		OP_FINISH,
		OP_BADTYPE,
		OP_MISMATCH
	} op_t;

	typedef enum logic [1:0] {
		EV_ACCESS      = 2'd0,
		EV_DONE        = 2'd1,
		EV_VERIFY_FAIL = 2'd2,
		EV_BAD_TYPE    = 2'd3
	} event_t;

	// sel: offset hi/lo, base set/add, or start-address byte lane
	typedef struct packed {
		op_t        op;
		logic [7:0] value;
		logic [1:0] sel;
	} cmd_t;

endpackage
`default_nettype wire

@@ sv/ihex_char_if.sv @@
// Input channel: text characters and verify-mismatch reports.
`timescale 1ns / 1ps
`default_nettype none
interface ihex_char_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_in;

	modport source (output valid, output kind, output char_in, input ready);
	modport sink (input valid, input kind, input char_in, output ready);
endinterface
`default_nettype wire

@@ sv/ihex_event_if.sv @@
// Output channel: memory accesses and load status events.
`timescale 1ns / 1ps
`default_nettype none
interface ihex_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [31:0] address;
	logic [7:0]  data;
	logic        verify;

	modport source (output valid, output event_res, output address, output data,
		output verify, input ready);
	modport sink (input valid, input event_res, input address, input data,
		input verify, output ready);
endinterface
`default_nettype wire

@@ sv/ihex_front.sv @@
// Front end: record parser that turns characters into loader commands.
`timescale 1ns / 1ps
`default_nettype none
module ihex_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ihex_char_if.sink     char_ch,
	input  wire logic     full,
	output logic          push,
	output ihex_pkg::cmd_t cmd
);
	import ihex_pkg::*;

	phase_t     phase_q, phase_d;
	logic       second_q, second_d;
	logic [3:0] high_q, high_d;
	logic [7:0] fidx_q, fidx_d;
	logic [7:0] len_q, len_d;
	logic [7:0] type_q, type_d;
	logic       end_q, end_d;
	logic       halted_q, halted_d;

	logic       work;
	logic [7:0] nib;
	logic [7:0] byte_val;
	logic [7:0] fidx_inc;
	logic       type_ok;

	assign char_ch.ready = halted_q || !full;
	assign work          = char_ch.valid && char_ch.ready && !halted_q;

	assign nib      = (char_ch.char_in > CHAR_NINE) ? char_ch.char_in - DIGIT_ALPHA
	                                               : char_ch.char_in - DIGIT_NUM;
	// low digit is ORed in at full width, as the byte rule demands
	assign byte_val = {high_q, 4'h0} | nib;
	assign fidx_inc = fidx_q + 8'd1;
	assign type_ok  = (type_q == REC_DATA) || (type_q == REC_EXT_LIN) ||
	                  (type_q == REC_START_LIN);

	// next record phase
	always_comb begin
		phase_d = phase_q;
		if (work && !char_ch.kind) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (char_ch.char_in == CHAR_COLON) phase_d = PH_LENGTH;
					else if (char_ch.char_in != CHAR_NL) phase_d = PH_SKIP;
				end
				PH_SKIP: begin
					if (char_ch.char_in == CHAR_NL && !end_q) phase_d = PH_WAIT;
				end
				PH_LENGTH: if (second_q) phase_d = PH_ADDR;
				PH_ADDR: if (second_q && fidx_q != 8'd0) phase_d = PH_TYPE;
				PH_TYPE: if (second_q) phase_d = PH_DATA;
				PH_DATA: begin
					if (second_q) begin
						if (type_q == REC_EOF) phase_d = PH_SKIP;
						else if (type_ok) begin
							if (len_q == 8'd0) phase_d = PH_SKIP;
							else if (fidx_inc == len_q) phase_d = PH_CHECKSUM;
						end
					end
				end
				PH_CHECKSUM: if (second_q) phase_d = PH_SKIP;
				default: phase_d = PH_SKIP;
			endcase
		end
	end

	// commands and field registers
	always_comb begin
		push      = 1'b0;
		cmd.op    = OP_OFFSET;
		cmd.value = byte_val;
		cmd.sel   = 2'd0;
		second_d  = second_q;
		high_d    = high_q;
		fidx_d    = fidx_q;
		len_d     = len_q;
		type_d    = type_q;
		end_d     = end_q;
		halted_d  = halted_q;
		if (work) begin
			if (char_ch.kind) begin
				push     = 1'b1;
				cmd.op   = OP_MISMATCH;
				halted_d = 1'b1;
			end else if (phase_q == PH_WAIT) begin
				if (char_ch.char_in == CHAR_COLON) second_d = 1'b0;
			end else if (phase_q == PH_SKIP) begin
				if (char_ch.char_in == CHAR_NL && end_q) begin
					push     = 1'b1;
					cmd.op   = OP_FINISH;
					halted_d = 1'b1;
				end
			end else if (!second_q) begin
				high_d   = nib[3:0];
				second_d = 1'b1;
			end else begin
				second_d = 1'b0;
				unique case (phase_q)
					PH_LENGTH: begin
						len_d  = byte_val;
						fidx_d = 8'd0;
					end
					PH_ADDR: begin
						push    = 1'b1;
						cmd.op  = OP_OFFSET;
						cmd.sel = (fidx_q == 8'd0) ? 2'd0 : 2'd1;
						fidx_d  = 8'd1;
					end
					PH_TYPE: begin
						type_d = byte_val;
						fidx_d = 8'd0;
					end
					PH_DATA: begin
						if (type_q == REC_EOF) begin
							end_d = 1'b1;
						end else if (!type_ok) begin
							push     = 1'b1;
							cmd.op   = OP_BADTYPE;
							halted_d = 1'b1;
						end else if (len_q != 8'd0) begin
							fidx_d = fidx_inc;
							if (type_q == REC_DATA) begin
								push   = 1'b1;
								cmd.op = OP_ACCESS;
							end else if (type_q == REC_EXT_LIN) begin
								push    = 1'b1;
								cmd.op  = OP_BASE;
								cmd.sel = (fidx_inc == 8'd1) ? 2'd0 : 2'd1;
							end else if (fidx_inc <= 8'd4) begin
								push    = 1'b1;
								cmd.op  = OP_START;
								cmd.sel = fidx_q[1:0];
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			second_q <= 1'b0;
			high_q   <= 4'h0;
			fidx_q   <= 8'd0;
			len_q    <= 8'd0;
			type_q   <= 8'd0;
			end_q    <= 1'b0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			second_q <= second_d;
			high_q   <= high_d;
			fidx_q   <= fidx_d;
			len_q    <= len_d;
			type_q   <= type_d;
			end_q    <= end_d;
			halted_q <= halted_d;
		end
	end

	a_no_cmd_after_halt: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !push)
		else $error("command queued after halt");

endmodule
`default_nettype wire

@@ sv/ihex_queue.sv @@
// Command queue between parser and executor.
`timescale 1ns / 1ps
`default_nettype none
module ihex_queue #(
	parameter int DEPTH = ihex_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ihex_pkg::cmd_t wr_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                avail,
	output ihex_pkg::cmd_t      rd_cmd
);
	import ihex_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign avail   = (count_q != '0);
	assign rd_cmd  = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full command queue");

endmodule
`default_nettype wire

@@ sv/ihex_back.sv @@
// Back end: executes loader commands and drives the event channel.
`timescale 1ns / 1ps
`default_nettype none
module ihex_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata,
	input  wire logic           avail,
	input  wire ihex_pkg::cmd_t head,
	output logic                pop,
	ihex_event_if.source        event_ch
);
	import ihex_pkg::*;

	logic        verify_mode_q;
	logic [15:0] offset_q;
	logic [31:0] base_q;
	logic [31:0] start_q;
	logic [31:0] last_q;
	logic        out_valid_q;
	event_t      ev_q;
	logic [31:0] addr_q;
	logic [7:0]  data_q;
	logic        verify_q;

	logic        produces;
	logic [31:0] acc_addr;

	always_comb begin
		case (head.op) inside
			OP_ACCESS, OP_FINISH, OP_BADTYPE, OP_MISMATCH: produces = 1'b1;
			default: produces = 1'b0;
		endcase
	end

	assign pop      = avail && (!produces || !out_valid_q || event_ch.ready);
	assign acc_addr = base_q + {16'h0, offset_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verify_mode_q <= 1'b0;
			offset_q      <= 16'h0;
			base_q        <= 32'h0;
			start_q       <= START_RESET;
			last_q        <= 32'h0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) verify_mode_q <= cfg_wdata;
			if (pop && produces) out_valid_q <= 1'b1;
			else if (event_ch.ready) out_valid_q <= 1'b0;
			if (pop) begin
				case (head.op)
					OP_OFFSET: begin
						if (head.sel == 2'd0) offset_q <= {head.value, 8'h00};
						else offset_q <= {offset_q[15:8], head.value};
					end
					OP_ACCESS: begin
						last_q   <= acc_addr;
						offset_q <= offset_q + 16'd1;
					end
					OP_BASE: begin
						if (head.sel == 2'd0) base_q <= {head.value, 24'h0};
						else base_q <= base_q + {8'h0, head.value, 16'h0};
					end
					OP_START: begin
						case (head.sel)
							2'd0: start_q <= {head.value, 24'h0};
							2'd1: start_q <= start_q + {8'h0, head.value, 16'h0};
							2'd2: start_q <= start_q + {16'h0, head.value, 8'h0};
							default: start_q <= start_q + {24'h0, head.value};
						endcase
					end
					default: ;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && produces) begin
			unique case (head.op)
				OP_ACCESS: begin
					ev_q     <= EV_ACCESS;
					addr_q   <= acc_addr;
					data_q   <= head.value;
					verify_q <= verify_mode_q;
				end
				OP_FINISH: begin
					ev_q     <= EV_DONE;
					addr_q   <= start_q;
					data_q   <= 8'h00;
					verify_q <= 1'b0;
				end
				OP_MISMATCH: begin
					ev_q     <= EV_VERIFY_FAIL;
					addr_q   <= last_q;
					data_q   <= 8'h00;
					verify_q <= 1'b0;
				end
				default: begin
					ev_q     <= EV_BAD_TYPE;
					addr_q   <= 32'h0;
					data_q   <= 8'h00;
					verify_q <= 1'b0;
				end
			endcase
		end
	end

	assign event_ch.valid     = out_valid_q;
	assign event_ch.event_res = ev_q;
	assign event_ch.address   = addr_q;
	assign event_ch.data      = data_q;
	assign event_ch.verify    = verify_q;

	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && produces) |=> out_valid_q)
		else $error("retired command lost its result");

endmodule
`default_nettype wire

@@ sv/intel_hex_record_loader.sv @@
// Top level of the Intel HEX record loader.
`timescale 1ns / 1ps
`default_nettype none
// Intel HEX loader: accepts one transaction per cycle on char_ch (a text
// character, or a verify-mismatch report with kind set) while the command
// queue is not full, and returns at most one event per transaction on
// event_ch. The record parser turns each character into at most one command;
// a QUEUE_DEPTH-entry command queue decouples it from the executor, which
// retires one command per cycle and stalls only while its output register
// holds an event not yet taken. A result passes through the command queue
// and then the executor's output register. Sustained rate is one character
// per cycle while the queue has room. After a finish or failure event all
// further input is accepted and dropped until reset. verify_mode is written
// through cfg_we/cfg_wdata and should only change while the block is idle.
module intel_hex_record_loader #(
	parameter int QUEUE_DEPTH = ihex_pkg::QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ihex_char_if.sink    char_ch,
	ihex_event_if.source event_ch,
	input  wire logic    cfg_we,
	input  wire logic    cfg_wdata
);
	import ihex_pkg::*;

	cmd_t wr_cmd, rd_cmd;
	logic push, full, pop, avail;

	ihex_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.full    (full),
		.push    (push),
		.cmd     (wr_cmd)
	);

	ihex_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.pop    (pop),
		.avail  (avail),
		.rd_cmd (rd_cmd)
	);

	ihex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.avail     (avail),
		.head      (rd_cmd),
		.pop       (pop),
		.event_ch  (event_ch)
	);

endmodule
`default_nettype wire
